// ----- sv/assert_macros.svh -----
// Assertion macros shared by the RTL files that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// ----- sv/ble_pkg.sv -----
// Package with the transaction types and request and status codes of the list engine.
package ble_pkg;

	// Request codes.
	localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
	localparam logic [2:0] REQ_POP_FRONT  = 3'd1;
	localparam logic [2:0] REQ_PUSH_BACK  = 3'd2;
	localparam logic [2:0] REQ_POP_BACK   = 3'd3;
	localparam logic [2:0] REQ_DUMP       = 3'd4;
	localparam logic [2:0] REQ_INSERT     = 3'd5;

	// Status codes.
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_POS   = 2'd2;
	localparam logic [1:0] ST_FULL  = 2'd3;

	// Data word width.
	localparam int DataW = 32;

	typedef struct packed {
		logic [2:0]              req_type;
		logic signed [DataW-1:0] value;
		logic [4:0]              position;
	} req_t;

	typedef struct packed {
		logic [1:0]              status;
		logic signed [DataW-1:0] data_out;
		logic                    last;
	} rsp_t;

endpackage

// ----- sv/ble_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered, enabled read port.
module ble_ram #(
	parameter int Width = 32,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	// Write port, and a read port whose data holds while no read is issued.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// ----- sv/bounded_list_engine_top.sv -----
// Bounded list engine: deque with positional insert, state held in one ring-buffer RAM.
// Requests are decoded in S_DEC; pushes and refusals respond from S_RESP, pops from S_POPW.
// An insert that shifts entries from logical index k moves them one place on in S_SHF, then
// writes in S_INS and responds from S_RESP; a tail insert skips S_SHF. Dump reads each
// element in S_DRD and loads it in S_DWT once the response slot is free. A new request is
// taken after the last response is loaded. Active-low async reset empties the list and idles.
`include "assert_macros.svh"

module bounded_list_engine_top #(
	parameter int DEPTH = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  ble_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output ble_pkg::rsp_t rsp
);
	import ble_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int EW = ((CW > 5) ? CW : 5) + 1;

	typedef enum logic [2:0] {
		S_IDLE, S_DEC, S_SHF, S_INS, S_DRD, S_DWT, S_POPW, S_RESP
	} state_t;

	state_t                  state_q;
	logic [AW-1:0]           hd_q;
	logic [CW-1:0]           cnt_q;
	logic [2:0]              type_q;
	logic [DataW-1:0]        val_q;
	logic [4:0]              pos_q;
	logic [AW-1:0]           k_q;
	logic [AW-1:0]           cur_q;
	logic                    rd_more_q;
	logic                    pend_s1;
	logic [AW-1:0]           widx_s1;
	logic [1:0]              st_q;
	logic                    rsp_valid_q;
	rsp_t                    rsp_q;

	logic                    we;
	logic [AW-1:0]           waddr;
	logic [DataW-1:0]        wdata;
	logic                    re;
	logic [AW-1:0]           raddr;
	logic [DataW-1:0]        rdata;

	logic                    full;
	logic                    empty;
	logic                    slot_free;
	logic                    rsp_load;
	logic [AW-1:0]           hd_dec;
	logic [AW-1:0]           hd_inc;
	logic [AW-1:0]           tail_idx;
	logic [AW-1:0]           last_idx;
	logic [EW-1:0]           pos_ext;
	logic [EW-1:0]           cnt_p1;
	logic [EW-1:0]           k_ext;

	// Maps a logical list index to a RAM address around the ring.
	function automatic logic [AW-1:0] phys(input logic [AW-1:0] hd, input logic [AW-1:0] l);
		logic [AW:0] s;
		s = {1'b0, hd} + {1'b0, l};
		if (s >= (AW+1)'(DEPTH)) begin
			s = s - (AW+1)'(DEPTH);
		end
		return s[AW-1:0];
	endfunction

	ble_ram #(
		.Width(DataW),
		.Depth(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	// Status of the list and helper indexes.
	assign full      = (cnt_q == CW'(DEPTH));
	assign empty     = (cnt_q == '0);
	assign slot_free = !rsp_valid_q || rsp_ready;
	assign hd_dec    = (hd_q == '0) ? AW'(DEPTH - 1) : hd_q - 1'b1;
	assign hd_inc    = (hd_q == AW'(DEPTH - 1)) ? '0 : hd_q + 1'b1;
	assign tail_idx  = AW'(cnt_q);
	assign last_idx  = AW'(cnt_q - 1'b1);
	assign pos_ext   = EW'(pos_q);
	assign cnt_p1    = EW'(cnt_q) + 1'b1;
	assign k_ext     = pos_ext - 1'b1;

	// A response is loaded in this cycle when a responding state finds the slot free.
	assign rsp_load  = slot_free &&
	                   (state_q == S_DWT || state_q == S_POPW || state_q == S_RESP);

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// RAM port control for each state.
	always_comb begin
		we    = 1'b0;
		waddr = phys(hd_q, k_q);
		wdata = val_q;
		re    = 1'b0;
		raddr = phys(hd_q, cur_q);
		unique case (state_q)
			S_DEC: begin
				if (!full && type_q == REQ_PUSH_FRONT) begin
					we    = 1'b1;
					waddr = hd_dec;
				end else if (!full && type_q == REQ_PUSH_BACK) begin
					we    = 1'b1;
					waddr = phys(hd_q, tail_idx);
				end else if (!empty && type_q == REQ_POP_FRONT) begin
					re    = 1'b1;
					raddr = hd_q;
				end else if (!empty && type_q == REQ_POP_BACK) begin
					re    = 1'b1;
					raddr = phys(hd_q, last_idx);
				end
			end
			S_SHF: begin
				re = rd_more_q;
				if (pend_s1) begin
					we    = 1'b1;
					waddr = phys(hd_q, widx_s1);
					wdata = rdata;
				end
			end
			S_INS: begin
				we = 1'b1;
			end
			S_DRD: begin
				re = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Sequencer with the list pointers and the response register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			hd_q        <= '0;
			cnt_q       <= '0;
			rd_more_q   <= 1'b0;
			pend_s1     <= 1'b0;
			rsp_valid_q <= 1'b0;
			type_q      <= '0;
			st_q        <= ST_OK;
			k_q         <= '0;
			cur_q       <= '0;
		end else begin
			if (rsp_ready && !rsp_load) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						type_q  <= req.req_type;
						val_q   <= req.value;
						pos_q   <= req.position;
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					unique case (type_q)
						REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
							state_q <= S_RESP;
							if (full) begin
								st_q <= ST_FULL;
							end else begin
								st_q  <= ST_OK;
								cnt_q <= cnt_q + 1'b1;
								if (type_q == REQ_PUSH_FRONT) begin
									hd_q <= hd_dec;
								end
							end
						end
						REQ_POP_FRONT, REQ_POP_BACK: begin
							if (empty) begin
								st_q    <= ST_EMPTY;
								state_q <= S_RESP;
							end else begin
								cnt_q   <= cnt_q - 1'b1;
								state_q <= S_POPW;
								if (type_q == REQ_POP_FRONT) begin
									hd_q <= hd_inc;
								end
							end
						end
						REQ_DUMP: begin
							if (empty) begin
								st_q    <= ST_EMPTY;
								state_q <= S_RESP;
							end else begin
								cur_q   <= '0;
								state_q <= S_DRD;
							end
						end
						REQ_INSERT: begin
							if (empty) begin
								st_q    <= ST_EMPTY;
								state_q <= S_RESP;
							end else if (pos_q == '0 || pos_ext > cnt_p1) begin
								st_q    <= ST_POS;
								state_q <= S_RESP;
							end else if (full) begin
								st_q    <= ST_FULL;
								state_q <= S_RESP;
							end else begin
								k_q <= AW'(k_ext);
								if (pos_ext == cnt_p1) begin
									state_q <= S_INS;
								end else begin
									cur_q     <= last_idx;
									rd_more_q <= 1'b1;
									state_q   <= S_SHF;
								end
							end
						end
						default: begin
							state_q <= S_IDLE;
						end
					endcase
				end
				S_SHF: begin
					// Read entry cur, then write it one place further on in the next cycle.
					pend_s1 <= rd_more_q;
					if (rd_more_q) begin
						widx_s1 <= cur_q + 1'b1;
						if (cur_q == k_q) begin
							rd_more_q <= 1'b0;
						end else begin
							cur_q <= cur_q - 1'b1;
						end
					end else if (pend_s1) begin
						state_q <= S_INS;
					end
				end
				S_INS: begin
					cnt_q   <= cnt_q + 1'b1;
					st_q    <= ST_OK;
					state_q <= S_RESP;
				end
				S_DRD: begin
					state_q <= S_DWT;
				end
				S_DWT: begin
					if (slot_free) begin
						rsp_valid_q   <= 1'b1;
						rsp_q.status  <= ST_OK;
						rsp_q.data_out <= rdata;
						rsp_q.last    <= (cur_q == last_idx);
						if (cur_q == last_idx) begin
							state_q <= S_IDLE;
						end else begin
							cur_q   <= cur_q + 1'b1;
							state_q <= S_DRD;
						end
					end
				end
				S_POPW: begin
					if (slot_free) begin
						rsp_valid_q    <= 1'b1;
						rsp_q.status   <= ST_OK;
						rsp_q.data_out <= rdata;
						rsp_q.last     <= 1'b1;
						state_q        <= S_IDLE;
					end
				end
				S_RESP: begin
					if (slot_free) begin
						rsp_valid_q    <= 1'b1;
						rsp_q.status   <= st_q;
						rsp_q.data_out <= '0;
						rsp_q.last     <= 1'b1;
						state_q        <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// The count never passes the capacity.
	`ASSERT_NOW(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= CW'(DEPTH))
	// A successful pop shrinks the list by exactly one entry.
	`ASSERT_NEXT(a_pop_dec, clk, arst_n, state_q == S_DEC && !empty && (type_q == REQ_POP_FRONT || type_q == REQ_POP_BACK), cnt_q == $past(cnt_q) - 1'b1)
	// While a shift overlaps reads and writes, they never touch the same entry.
	`ASSERT_NOW(a_no_rw_clash, clk, arst_n, we && re, waddr != raddr)
	// A dump never modifies the stored list.
	`ASSERT_NOW(a_dump_ro, clk, arst_n, state_q == S_DRD || state_q == S_DWT, !we)
endmodule
